/* hdl/ffba_pkg.sv */
// shared types and constants of the first-fit block allocator
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int SIZE_W  = 20;
  localparam int PADDR_W = 20;
  localparam int LIMIT_W = 21;
  localparam int STAT_W  = 3;

  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 21'd1048576;

  typedef enum logic [STAT_W-1:0] {
    ST_REUSED  = 3'd0,
    ST_NEW     = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_FREED   = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_DONE
  } state_t;

  typedef enum logic {
    K_ALLOC = 1'b0,
    K_FREE  = 1'b1
  } kind_t;

  typedef struct packed {
    logic               kind;
    logic [SIZE_W-1:0]  request_size;
    logic [PADDR_W-1:0] payload_address;
  } req_t;

  typedef struct packed {
    logic [PADDR_W-1:0] result_address;
    status_t            status;
  } res_t;

  // one block table entry: payload address, payload size, free mark
  typedef struct packed {
    logic [LIMIT_W-1:0] payload;
    logic [SIZE_W-1:0]  size;
    logic               free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

/* hdl/ffba_if.sv */
// request, result and configuration channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface ffba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ffba_pkg::SIZE_W-1:0]  request_size;
  logic [ffba_pkg::PADDR_W-1:0] payload_address;

  modport source (output valid, kind, request_size, payload_address, input ready);
  modport sink (input valid, kind, request_size, payload_address, output ready);
endinterface

interface ffba_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::PADDR_W-1:0] result_address;
  ffba_pkg::status_t            status;

  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

interface ffba_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ffba_pkg::LIMIT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/ffba_ram.sv */
// generic single-write single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                              clk,
  input  wire logic                                              wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      wr_addr,
  input  wire logic [WIDTH-1:0]                                  wr_data,
  input  wire logic                                              rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]      rd_addr,
  output logic      [WIDTH-1:0]                                  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ffba_ctrl.sv */
// sequencer that scans the block table and performs allocate and free requests
`timescale 1ns / 1ps
`default_nettype none

module ffba_ctrl #(
  parameter int MAX_BLOCKS   = 16,
  parameter int HEADER_BYTES = 24,
  parameter int ADDR_BITS    = 20
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire ffba_pkg::req_t               req,
  input  wire logic [ffba_pkg::LIMIT_W-1:0] heap_limit,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output ffba_pkg::res_t                    res
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W = ffba_pkg::LIMIT_W + 2;
  localparam int CMP_W = 34;
  localparam logic [CMP_W-1:0] SPAN = CMP_W'(1) << ADDR_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

  ffba_pkg::state_t state_r, state_nxt;
  ffba_pkg::req_t   req_r, req_nxt;
  ffba_pkg::res_t   res_r, res_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic [ffba_pkg::LIMIT_W-1:0] top_r, top_nxt;

  logic                          rd_en;
  logic [ffba_pkg::ENTRY_W-1:0]  rd_data;
  ffba_pkg::entry_t              rd_entry;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  ffba_pkg::entry_t              wr_entry;

  logic             hit, last, accept;
  logic [SUM_W-1:0] payload, new_top;
  logic [CMP_W-1:0] limit;
  logic             fail;

  assign rd_entry = ffba_pkg::entry_t'(rd_data);
  assign accept   = req_valid && req_ready;

  always_comb begin
    if (req_r.kind == ffba_pkg::K_FREE) begin
      hit = (rd_entry.payload == {1'b0, req_r.payload_address});
    end else begin
      hit = rd_entry.free && (rd_entry.size >= req_r.request_size);
    end
  end

  assign last = (CNT_W'(chk_idx_r) + CNT_W'(1)) == count_r;

  // append check against the table depth and the smaller of the heap limit and the address span
  assign payload = SUM_W'(top_r) + SUM_W'(HEADER_BYTES);
  assign new_top = payload + SUM_W'(req_r.request_size);
  assign limit   = (CMP_W'(heap_limit) < SPAN) ? CMP_W'(heap_limit) : SPAN;
  assign fail    = (count_r >= CNT_MAX) || (CMP_W'(new_top) > limit)
                   || (CMP_W'(payload) >= SPAN);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (accept) begin
          if (count_r != '0) begin
            state_nxt = ffba_pkg::S_SCAN;
          end else if (req.kind == ffba_pkg::K_FREE) begin
            state_nxt = ffba_pkg::S_DONE;
          end else begin
            state_nxt = ffba_pkg::S_APPEND;
          end
        end
      end
      ffba_pkg::S_SCAN: begin
        if (rd_valid_r) begin
          if (hit || (last && req_r.kind == ffba_pkg::K_FREE)) begin
            state_nxt = ffba_pkg::S_DONE;
          end else if (last) begin
            state_nxt = ffba_pkg::S_APPEND;
          end
        end
      end
      ffba_pkg::S_APPEND: state_nxt = ffba_pkg::S_DONE;
      ffba_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = ffba_pkg::S_IDLE;
        end
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready    = 1'b0;
    res_valid    = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = chk_idx_r;
    wr_entry     = rd_entry;
    req_nxt      = req_r;
    res_nxt      = res_r;
    count_nxt    = count_r;
    top_nxt      = top_r;
    rd_idx_nxt   = rd_idx_r;
    chk_idx_nxt  = chk_idx_r;
    rd_valid_nxt = 1'b0;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        req_ready  = 1'b1;
        rd_idx_nxt = '0;
        if (accept) begin
          req_nxt = req;
          res_nxt = '{result_address: '0, status: ffba_pkg::ST_IGNORED};
        end
      end
      ffba_pkg::S_SCAN: begin
        rd_en        = rd_idx_r < count_r;
        rd_valid_nxt = rd_en;
        chk_idx_nxt  = rd_idx_r[IDX_W-1:0];
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
        if (rd_valid_r && hit) begin
          wr_en         = 1'b1;
          wr_entry.free = req_r.kind;
          if (req_r.kind == ffba_pkg::K_FREE) begin
            res_nxt = '{result_address: '0, status: ffba_pkg::ST_FREED};
          end else begin
            res_nxt = '{result_address: rd_entry.payload[ffba_pkg::PADDR_W-1:0],
                        status: ffba_pkg::ST_REUSED};
          end
        end
      end
      ffba_pkg::S_APPEND: begin
        if (fail) begin
          res_nxt = '{result_address: '0, status: ffba_pkg::ST_NOSPACE};
        end else begin
          wr_en     = 1'b1;
          wr_addr   = count_r[IDX_W-1:0];
          wr_entry  = '{payload: payload[ffba_pkg::LIMIT_W-1:0],
                        size: req_r.request_size, free: 1'b0};
          count_nxt = count_r + CNT_W'(1);
          top_nxt   = new_top[ffba_pkg::LIMIT_W-1:0];
          res_nxt   = '{result_address: payload[ffba_pkg::PADDR_W-1:0],
                        status: ffba_pkg::ST_NEW};
        end
      end
      ffba_pkg::S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ffba_pkg::S_IDLE;
      count_r    <= '0;
      top_r      <= '0;
      rd_valid_r <= 1'b0;
      rd_idx_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      top_r      <= top_nxt;
      rd_valid_r <= rd_valid_nxt;
      rd_idx_r   <= rd_idx_nxt;
    end
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    chk_idx_r <= chk_idx_nxt;
  end

  ffba_ram #(
    .WIDTH (ffba_pkg::ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("block count above table depth");

  a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::S_SCAN && rd_valid_r) |-> (CNT_W'(chk_idx_r) < count_r))
    else $error("checked entry beyond block count");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ffba_pkg::S_SCAN || state_r == ffba_pkg::S_APPEND))
    else $error("table write outside scan or append");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffba_pkg::S_APPEND && wr_en) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not grow the block count");

endmodule

`default_nettype wire

/* hdl/first_fit_block_allocator_core.sv */
// Allocate and free requests over a first-fit block table of MAX_BLOCKS entries held in one
// single-port-read ram. Requests are taken one at a time. An allocate request reads the table
// one entry per cycle through the ram read port until the first free block that is large
// enough; if none fits it appends a block at the heap top when the table and the heap and
// address limits leave room. A free request scans the same way for the matching payload
// address. With an empty table an allocate request appends directly and a free request ends
// without a scan. The finished result sits in an output register, so a new request is
// accepted while the previous result still waits. The table needs no clearing after reset:
// only entries below the block count are ever read. heap_limit is written through the
// configuration channel, which is always ready, and should only be changed while idle.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator_core #(
  parameter int MAX_BLOCKS   = 16,
  parameter int HEADER_BYTES = 24,
  parameter int ADDR_BITS    = 20
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ffba_req_if.sink   in_req,
  ffba_rsp_if.source out_rsp,
  ffba_cfg_if.sink   cfg_wr
);

  logic [ffba_pkg::LIMIT_W-1:0] heap_limit_r;
  logic                         out_valid_r, out_valid_nxt;
  ffba_pkg::res_t               out_res_r, out_res_nxt;
  ffba_pkg::req_t               req;
  ffba_pkg::res_t               res;
  logic                         res_valid, res_ready;

  assign cfg_wr.ready = 1'b1;

  assign req = '{kind: in_req.kind, request_size: in_req.request_size,
                 payload_address: in_req.payload_address};

  assign res_ready = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_limit_r <= ffba_pkg::HEAP_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        heap_limit_r <= cfg_wr.data;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.result_address = out_res_r.result_address;
  assign out_rsp.status         = out_res_r.status;

  ffba_ctrl #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_req.valid),
    .req_ready  (in_req.ready),
    .req        (req),
    .heap_limit (heap_limit_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

`default_nettype wire
